[rtl/jet_pkg.sv]
// Shared types, register indexes, reset values and saturation for the Julia escape-time block.
`default_nettype none
package jet_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

    // reset values
    localparam logic signed [31:0] RST_X_MIN    = -32'sd536870912;
    localparam logic [30:0]        RST_X_STEP   = 31'd2097152;
    localparam logic signed [31:0] RST_Y_MIN    = -32'sd536870912;
    localparam logic [30:0]        RST_Y_STEP   = 31'd2097152;
    localparam logic signed [31:0] RST_C_REAL   = -32'sd187904819;
    localparam logic signed [31:0] RST_C_IMAG   = 32'sd72517838;
    localparam logic [7:0]         RST_MAX_ITER = 8'd100;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [8:0] column;
        logic [8:0] row;
    } in_item_t;

    typedef struct packed {
        logic [8:0] out_column;
        logic [8:0] out_row;
        logic [7:0] escape_count;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic [30:0]        x_step;
        logic signed [31:0] y_min;
        logic [30:0]        y_step;
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic [7:0]         max_iterations;
    } cfg_t;

    // clamp a wide signed value to the Q4.28 range
    function automatic logic signed [31:0] sat_q(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v[41:31] == {11{v[41]}}) begin
            r = $signed(v[31:0]);
        end else if (v[41]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/jet_cfg.sv]
// Configuration register file for the Julia escape-time block.
`default_nettype none
module jet_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [jet_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [31:0]                   wr_data,
    output jet_pkg::cfg_t                      cfg
);

    jet_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min          <= jet_pkg::RST_X_MIN;
            cfg_reg.x_step         <= jet_pkg::RST_X_STEP;
            cfg_reg.y_min          <= jet_pkg::RST_Y_MIN;
            cfg_reg.y_step         <= jet_pkg::RST_Y_STEP;
            cfg_reg.c_real         <= jet_pkg::RST_C_REAL;
            cfg_reg.c_imag         <= jet_pkg::RST_C_IMAG;
            cfg_reg.max_iterations <= jet_pkg::RST_MAX_ITER;
        end else if (wr_en) begin
            unique case (wr_index)
                jet_pkg::REG_X_MIN:    cfg_reg.x_min          <= $signed(wr_data);
                jet_pkg::REG_X_STEP:   cfg_reg.x_step         <= wr_data[30:0];
                jet_pkg::REG_Y_MIN:    cfg_reg.y_min          <= $signed(wr_data);
                jet_pkg::REG_Y_STEP:   cfg_reg.y_step         <= wr_data[30:0];
                jet_pkg::REG_C_REAL:   cfg_reg.c_real         <= $signed(wr_data);
                jet_pkg::REG_C_IMAG:   cfg_reg.c_imag         <= $signed(wr_data);
                jet_pkg::REG_MAX_ITER: cfg_reg.max_iterations <= wr_data[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/jet_mul.sv]
// Shared registered 32x32 signed multiplier.
`default_nettype none
module jet_mul (
    input  wire logic               aclk,
    input  wire logic signed [31:0] op_a,
    input  wire logic signed [31:0] op_b,
    output logic signed [63:0]      prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[rtl/jet_core.sv]
// Sequencer and datapath: start point, z = z^2 + c iteration and escape test.
`default_nettype none
module jet_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jet_pkg::cfg_t     cfg,
    input  wire logic              start,
    input  wire jet_pkg::in_item_t in_item,
    output logic                   ready,
    output logic                   done,
    input  wire logic              res_ready,
    output jet_pkg::out_item_t     result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SX   = 4'd1;
    localparam logic [3:0] S_SY   = 4'd2;
    localparam logic [3:0] S_ZY   = 4'd3;
    localparam logic [3:0] S_XX   = 4'd4;
    localparam logic [3:0] S_YY   = 4'd5;
    localparam logic [3:0] S_XY   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [8:0]         col_reg, row_reg;
    logic [7:0]         count_reg, count_next;
    logic signed [31:0] zx_reg, zx_next;
    logic signed [31:0] zy_reg, zy_next;
    logic signed [63:0] xx_reg, xx_next;
    logic signed [63:0] diff_reg, diff_next;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;
    logic [63:0]        mag_sum;
    logic signed [41:0] start_x, start_y, iter_x, iter_y;

    jet_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // operand select for the shared multiplier; the product is registered and appears in the next cycle
    always_comb begin
        unique case (state_reg)
            S_SX: begin
                op_a = $signed({23'd0, col_reg});
                op_b = $signed({1'b0, cfg.x_step});
            end
            S_SY: begin
                op_a = $signed({23'd0, row_reg});
                op_b = $signed({1'b0, cfg.y_step});
            end
            S_XX: begin
                op_a = zx_reg;
                op_b = zx_reg;
            end
            S_YY: begin
                op_a = zy_reg;
                op_b = zy_reg;
            end
            default: begin
                op_a = zx_reg;
                op_b = zy_reg;
            end
        endcase
    end

    // product of a 9-bit index and a 31-bit step stays below 2^40
    assign start_x = {{10{cfg.x_min[31]}}, cfg.x_min} + $signed(prod[41:0]);
    assign start_y = {{10{cfg.y_min[31]}}, cfg.y_min} + $signed(prod[41:0]);
    assign iter_x  = $signed({{6{diff_reg[63]}}, diff_reg[63:28]})
                   + {{10{cfg.c_real[31]}}, cfg.c_real};
    // 2*zx*zy in Q4.28 is the product shifted by one less
    assign iter_y  = $signed({{5{prod[63]}}, prod[63:27]})
                   + {{10{cfg.c_imag[31]}}, cfg.c_imag};
    // both squares are non-negative, so the unsigned sum cannot wrap
    assign mag_sum = $unsigned(xx_reg) + $unsigned(prod);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;
        xx_next    = xx_reg;
        diff_next  = diff_reg;
        unique case (state_reg)
            S_IDLE: begin
                count_next = 8'd0;
                if (start) state_next = S_SX;
            end
            S_SX: state_next = S_SY;
            S_SY: begin
                zx_next    = jet_pkg::sat_q(start_x);
                state_next = S_ZY;
            end
            S_ZY: begin
                zy_next    = jet_pkg::sat_q(start_y);
                state_next = S_XX;
            end
            S_XX: begin
                if (count_reg >= cfg.max_iterations) state_next = S_DONE;
                else                                 state_next = S_YY;
            end
            S_YY: begin
                xx_next    = prod;
                state_next = S_XY;
            end
            S_XY: begin
                diff_next = xx_reg - prod;
                // |z|^2 >= 4.0 in Q8.56
                if (mag_sum[63:58] != 6'd0) state_next = S_DONE;
                else                         state_next = S_UPD;
            end
            S_UPD: begin
                zx_next    = jet_pkg::sat_q(iter_x);
                zy_next    = jet_pkg::sat_q(iter_y);
                count_next = count_reg + 8'd1;
                state_next = S_XX;
            end
            S_DONE: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            col_reg <= in_item.column;
            row_reg <= in_item.row;
        end
        count_reg <= count_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        xx_reg    <= xx_next;
        diff_reg  <= diff_next;
    end

    assign ready               = (state_reg == S_IDLE);
    assign done                = (state_reg == S_DONE);
    assign result.out_column   = col_reg;
    assign result.out_row      = row_reg;
    assign result.escape_count = count_reg;

endmodule
`default_nettype wire

[rtl/julia_escape_time_pixel_top.sv]
// Top level of the Julia escape-time pixel block: config, core and output register.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | s_data   (column, row)
//   m_      | out       | m_valid / m_ready   | m_data   (out_column, out_row, escape_count)
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item is iterated from accept until it stops at the limit after n iterations
// or escapes during iteration n+1; the default limit is 100. The single shared
// multiplier does three products per iteration.
// Synchronous active-low reset restores the register defaults; there is no clearing pass.
// The finished result sits in the output register, so the next item is
// accepted while it waits; the core stalls only when that register is still full.
`default_nettype none
module julia_escape_time_pixel_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire jet_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output jet_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [jet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    jet_pkg::cfg_t      cfg;
    jet_pkg::out_item_t core_result;
    jet_pkg::out_item_t m_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic               core_ready, core_done, out_free, out_load;

    assign cfg_ready = 1'b1;

    jet_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    jet_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .start     (s_valid),
        .in_item   (s_data),
        .ready     (core_ready),
        .done      (core_done),
        .res_ready (out_free),
        .result    (core_result)
    );

    assign s_ready  = core_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = core_done && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= core_result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // one item at a time: the core is busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while core busy");

    // a finished count never exceeds the limit it was run against
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.escape_count <= cfg.max_iterations)
        else $error("escape count above iteration limit");

    // a result handed over by the core shows up at the output next cycle
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done && out_free |=> m_valid && !core_done)
        else $error("core result not moved to output register");
`endif

endmodule
`default_nettype wire
